@@ rtl/core/sdrh_pkg.sv @@
// sdrh_pkg: constants, codes and shared types of the substring double rolling hash
// no dependencies; every other file of the block refers to it by scoped names
`timescale 1ns / 1ps

package sdrh_pkg;

  // default text capacity in bytes
  localparam int unsigned MAX_LEN = 4096;

  // field widths of the item channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned HA_W     = 29;
  localparam int unsigned HB_W     = 30;
  localparam int unsigned SPAN_W   = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PAIR_W   = HA_W + HB_W;

  // hash bases and prime moduli
  localparam logic [HA_W-1:0] BASE_A = HA_W'(3491);
  localparam logic [HA_W-1:0] MOD_A  = HA_W'(481840747);
  localparam logic [HB_W-1:0] BASE_B = HB_W'(8761);
  localparam logic [HB_W-1:0] MOD_B  = HB_W'(999750347);

  // number of multiplier bits that cover both bases
  localparam int unsigned BASE_STEPS = 14;

  // command queue depth, a power of two
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // classified item kinds handed from front to back
  typedef enum logic [2:0] {
    K_APPEND,
    K_FULL,
    K_QUERY,
    K_BAD,
    K_CLEAR,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
  } cmd_t;

  // control of one modular multiply lane
  typedef struct packed {
    logic load;
    logic full_width;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_PREHI,
    S_MUL,
    S_FIX,
    S_OUT
  } bk_state_e;

endpackage

@@ rtl/core/sdrh_if.sv @@
// sdrh_if: valid/ready item channels for requests and results
// depends on sdrh_pkg for field widths
`timescale 1ns / 1ps

interface sdrh_in_if;
  logic                             valid;
  logic                             ready;
  logic [sdrh_pkg::OP_W-1:0]        operation;
  logic [sdrh_pkg::CHAR_W-1:0]      char_code;
  logic [sdrh_pkg::POS_W-1:0]       start_req;
  logic [sdrh_pkg::POS_W-1:0]       stop;

  modport source (output valid, output operation, output char_code,
                  output start_req, output stop, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input start_req, input stop, output ready);
endinterface

interface sdrh_out_if;
  logic                             valid;
  logic                             ready;
  logic [sdrh_pkg::HA_W-1:0]        hash_a;
  logic [sdrh_pkg::HB_W-1:0]        hash_b;
  logic [sdrh_pkg::SPAN_W-1:0]      span_length;
  logic [sdrh_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output hash_a, output hash_b,
                  output span_length, output status, input ready);
  modport sink   (input valid, input hash_a, input hash_b,
                  input span_length, input status, output ready);
endinterface

@@ rtl/core/substring_double_rolling_hash.sv @@
// Substring double rolling hash: keeps a text as two polynomial prefix-hash tables
// (base 3491 mod 481840747, base 8761 mod 999750347) plus base-power tables.
// Request channel in_i: operation 0 appends char_code, 1 returns the double hash of
// positions start_req..stop-1, 2 clears the text. Result channel out_o: exactly one
// result item per request, in order, with hash_a, hash_b, span_length and status.
// A front stage classifies each item and tracks the length; a two-entry queue feeds
// the back stage, so requests are taken while a result waits on a stalled receiver.
// Back stage work per item, set by the bit-serial modular multiply lanes:
//   append         14 multiplier bits of the base
//   query          30 bits of the stored power
//   full, invalid range, clear, unused code: no multiply
// plus the result hand-off, which waits until the receiver is ready.
// Reset empties the queue and sets the text length to zero; table contents are
// kept and only entries below the length are read, so no clearing pass is run.
// A stalled receiver holds the result register; the back stage waits and the
// queue then fills, after which in_i.ready drops.
// depends on sdrh_pkg, sdrh_if, sdrh_front, sdrh_fifo, sdrh_back
`timescale 1ns / 1ps

module substring_double_rolling_hash #(
  parameter int unsigned MAX_LEN = sdrh_pkg::MAX_LEN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdrh_in_if.sink     in_i,
  sdrh_out_if.source  out_o
);

  logic           f_valid, f_ready, b_valid, b_ready;
  sdrh_pkg::cmd_t f_cmd, b_cmd;

  // front: accept and classify
  sdrh_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd)
  );

  // queue between front and back
  sdrh_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_data_i(f_cmd),
    .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_data_o(b_cmd)
  );

  // back: tables, multiply lanes and result register
  sdrh_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd), .out_o
  );

endmodule

@@ rtl/core/sdrh_front.sv @@
// sdrh_front: accepts request items, tracks the text length and classifies each item
// depends on sdrh_pkg and sdrh_in_if
`timescale 1ns / 1ps

module sdrh_front #(
  parameter int unsigned MAX_LEN = sdrh_pkg::MAX_LEN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sdrh_in_if.sink         in_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output sdrh_pkg::cmd_t  cmd_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0]   len_q, len_d;
  logic            accept;
  logic            range_ok;
  sdrh_pkg::kind_e kind;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign accept      = in_i.valid && cmd_ready_i;

  // query range check against the length seen by this item
  assign range_ok = (32'(in_i.start_req) < 32'(len_q)) &&
                    (in_i.start_req <= in_i.stop) &&
                    (32'(in_i.stop) <= 32'(len_q));

  // classify and update the length
  always_comb begin
    len_d = len_q;
    kind  = sdrh_pkg::K_NOP;
    case (sdrh_pkg::op_e'(in_i.operation))
      sdrh_pkg::OP_APPEND: begin
        if (len_q == LW'(MAX_LEN)) begin
          kind = sdrh_pkg::K_FULL;
        end else begin
          kind  = sdrh_pkg::K_APPEND;
          len_d = len_q + LW'(1);
        end
      end
      sdrh_pkg::OP_QUERY: begin
        kind = range_ok ? sdrh_pkg::K_QUERY : sdrh_pkg::K_BAD;
      end
      sdrh_pkg::OP_CLEAR: begin
        kind  = sdrh_pkg::K_CLEAR;
        len_d = '0;
      end
      default: begin
        kind = sdrh_pkg::K_NOP;
      end
    endcase
  end

  assign cmd_o.kind      = kind;
  assign cmd_o.char_code = in_i.char_code;
  assign cmd_o.lo        = in_i.start_req;
  assign cmd_o.hi        = in_i.stop;

  // text length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (accept) begin
      len_q <= len_d;
    end
  end

endmodule

@@ rtl/core/sdrh_fifo.sv @@
// sdrh_fifo: short command queue between the front and the back
// depends on sdrh_pkg for the command type and depth
`timescale 1ns / 1ps

module sdrh_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sdrh_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sdrh_pkg::cmd_t  pop_data_o
);

  localparam int unsigned DEPTH = sdrh_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sdrh_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/sdrh_modmul.sv @@
// sdrh_modmul: bit-serial modular multiplier, one multiplier bit per cycle, msb first
// depends on sdrh_pkg for the lane control type and base step count
`timescale 1ns / 1ps

module sdrh_modmul #(
  parameter int unsigned W = sdrh_pkg::HB_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdrh_pkg::lane_ctrl_t ctrl_i,
  input  logic [W-1:0]         a_i,
  input  logic [W-1:0]         b_i,
  input  logic [W-1:0]         mod_i,
  output logic [W-1:0]         r_o,
  output logic                 done_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  a_q, b_q, r_q;
  logic [CW-1:0] cnt_q;
  logic [W+1:0]  acc, acc_red, one_m, two_m;

  // r = 2r + bit * a, brought back below the modulus (sum stays under 3m)
  always_comb begin
    one_m = {2'b00, mod_i};
    two_m = {1'b0, mod_i, 1'b0};
    acc   = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
    if (acc >= two_m) begin
      acc_red = acc - two_m;
    end else if (acc >= one_m) begin
      acc_red = acc - one_m;
    end else begin
      acc_red = acc;
    end
  end

  assign r_o    = r_q;
  assign done_o = (cnt_q == '0);

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.load) begin
      cnt_q <= ctrl_i.full_width ? CW'(W) : CW'(sdrh_pkg::BASE_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // operands and running remainder; a short multiplier is aligned to the msb
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q <= a_i;
      b_q <= ctrl_i.full_width ? b_i : (b_i << (W - sdrh_pkg::BASE_STEPS));
      r_q <= '0;
    end else if (cnt_q != '0) begin
      b_q <= b_q << 1;
      r_q <= acc_red[W-1:0];
    end
  end

endmodule

@@ rtl/core/sdrh_back.sv @@
// sdrh_back: executes classified items against the prefix and power tables
// depends on sdrh_pkg, sdrh_out_if and sdrh_modmul
`timescale 1ns / 1ps

module sdrh_back #(
  parameter int unsigned MAX_LEN = sdrh_pkg::MAX_LEN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  sdrh_pkg::cmd_t  cmd_i,
  sdrh_out_if.source      out_o
);

  localparam int unsigned AW     = $clog2(MAX_LEN);
  localparam int unsigned LW     = $clog2(MAX_LEN + 1);
  localparam int unsigned HA_W   = sdrh_pkg::HA_W;
  localparam int unsigned HB_W   = sdrh_pkg::HB_W;
  localparam int unsigned PAIR_W = sdrh_pkg::PAIR_W;
  localparam int unsigned POS_W  = sdrh_pkg::POS_W;
  localparam int unsigned SPAN_W = sdrh_pkg::SPAN_W;

  sdrh_pkg::bk_state_e state_q, state_d;
  logic [LW-1:0]       len_q, len_d;
  sdrh_pkg::cmd_t      cmd_q, cmd_d;
  logic [HA_W-1:0]     pre_hi_a_q, pre_hi_a_d;
  logic [HB_W-1:0]     pre_hi_b_q, pre_hi_b_d;
  logic [HA_W-1:0]     out_ha_q, out_ha_d;
  logic [HB_W-1:0]     out_hb_q, out_hb_d;
  logic [SPAN_W-1:0]   out_span_q, out_span_d;
  sdrh_pkg::status_e   out_stat_q, out_stat_d;

  // tables: low part hash a, high part hash b
  logic [PAIR_W-1:0] pre_mem [MAX_LEN];
  logic [PAIR_W-1:0] pow_mem [MAX_LEN];
  logic [PAIR_W-1:0] pre_rd_q, pow_rd_q;
  logic              pre_re, pow_re, wr_en;
  logic [AW-1:0]     pre_addr, pow_addr, wr_addr;
  logic [PAIR_W-1:0] pre_wdata, pow_wdata;

  // multiply lanes
  sdrh_pkg::lane_ctrl_t pre_ctrl, pow_ctrl;
  logic [HA_W-1:0]      pre_a_op, pre_a_mul, pow_a_op, r_pre_a, r_pow_a;
  logic [HB_W-1:0]      pre_b_op, pre_b_mul, pow_b_op, r_pre_b, r_pow_b;
  logic                 done_pre_a, done_pre_b, done_pow_a, done_pow_b;

  logic [POS_W-1:0] span;
  logic             is_append;
  logic [HA_W:0]    add_a, sub_a;
  logic [HB_W:0]    add_b, sub_b;
  logic [HA_W-1:0]  new_a, diff_a;
  logic [HB_W-1:0]  new_b, diff_b;

  assign span      = cmd_q.hi - cmd_q.lo;
  assign is_append = (cmd_q.kind == sdrh_pkg::K_APPEND);

  // append: add the byte to the shifted prefix, then one subtract
  assign add_a = {1'b0, r_pre_a} + (HA_W + 1)'(cmd_q.char_code);
  assign add_b = {1'b0, r_pre_b} + (HB_W + 1)'(cmd_q.char_code);
  assign new_a = (add_a >= {1'b0, sdrh_pkg::MOD_A}) ?
                 HA_W'(add_a - {1'b0, sdrh_pkg::MOD_A}) : add_a[HA_W-1:0];
  assign new_b = (add_b >= {1'b0, sdrh_pkg::MOD_B}) ?
                 HB_W'(add_b - {1'b0, sdrh_pkg::MOD_B}) : add_b[HB_W-1:0];

  // query: later prefix minus the shifted earlier prefix, add back on borrow
  assign sub_a  = {1'b0, pre_hi_a_q} - {1'b0, r_pre_a};
  assign sub_b  = {1'b0, pre_hi_b_q} - {1'b0, r_pre_b};
  assign diff_a = sub_a[HA_W] ? HA_W'(sub_a + {1'b0, sdrh_pkg::MOD_A}) : sub_a[HA_W-1:0];
  assign diff_b = sub_b[HB_W] ? HB_W'(sub_b + {1'b0, sdrh_pkg::MOD_B}) : sub_b[HB_W-1:0];

  assign wr_addr   = AW'(len_q);
  assign pre_wdata = {new_b, new_a};
  assign pow_wdata = {r_pow_b, r_pow_a};

  // sequencer: next state, table accesses, lane loads and result capture
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    pre_hi_a_d  = pre_hi_a_q;
    pre_hi_b_d  = pre_hi_b_q;
    out_ha_d    = out_ha_q;
    out_hb_d    = out_hb_q;
    out_span_d  = out_span_q;
    out_stat_d  = out_stat_q;
    cmd_ready_o = 1'b0;
    pre_re      = 1'b0;
    pow_re      = 1'b0;
    wr_en       = 1'b0;
    pre_addr    = '0;
    pow_addr    = '0;
    pre_ctrl    = '0;
    pow_ctrl    = '0;
    pre_a_op    = '0;
    pre_b_op    = '0;
    pre_a_mul   = sdrh_pkg::BASE_A;
    pre_b_mul   = sdrh_pkg::BASE_B;
    pow_a_op    = '0;
    pow_b_op    = '0;
    case (state_q)
      sdrh_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          cmd_d       = cmd_i;
          out_ha_d    = '0;
          out_hb_d    = '0;
          out_span_d  = '0;
          out_stat_d  = sdrh_pkg::ST_OK;
          case (cmd_i.kind)
            sdrh_pkg::K_APPEND, sdrh_pkg::K_QUERY: begin
              state_d = sdrh_pkg::S_READ;
            end
            sdrh_pkg::K_FULL: begin
              out_span_d = SPAN_W'(len_q);
              out_stat_d = sdrh_pkg::ST_FULL;
              state_d    = sdrh_pkg::S_OUT;
            end
            sdrh_pkg::K_BAD: begin
              out_stat_d = sdrh_pkg::ST_RANGE;
              state_d    = sdrh_pkg::S_OUT;
            end
            sdrh_pkg::K_CLEAR: begin
              len_d   = '0;
              state_d = sdrh_pkg::S_OUT;
            end
            default: begin
              state_d = sdrh_pkg::S_OUT;
            end
          endcase
        end
      end
      sdrh_pkg::S_READ: begin
        pre_re = 1'b1;
        pow_re = 1'b1;
        if (is_append) begin
          pre_addr = AW'(len_q - LW'(1));
          pow_addr = AW'(len_q - LW'(1));
        end else begin
          pre_addr = AW'(32'(cmd_q.lo) - 32'd1);
          pow_addr = AW'(32'(span) - 32'd1);
        end
        state_d = sdrh_pkg::S_LOAD;
      end
      sdrh_pkg::S_LOAD: begin
        pre_ctrl.load = 1'b1;
        if (is_append) begin
          // empty prefix hashes to zero, zeroth power is one
          pow_ctrl.load = 1'b1;
          if (len_q != '0) begin
            pre_a_op = pre_rd_q[HA_W-1:0];
            pre_b_op = pre_rd_q[PAIR_W-1:HA_W];
            pow_a_op = pow_rd_q[HA_W-1:0];
            pow_b_op = pow_rd_q[PAIR_W-1:HA_W];
          end else begin
            pow_a_op = HA_W'(1);
            pow_b_op = HB_W'(1);
          end
          state_d = sdrh_pkg::S_MUL;
        end else begin
          pre_ctrl.full_width = 1'b1;
          if (cmd_q.lo != '0) begin
            pre_a_op = pre_rd_q[HA_W-1:0];
            pre_b_op = pre_rd_q[PAIR_W-1:HA_W];
          end
          if (span != '0) begin
            pre_a_mul = pow_rd_q[HA_W-1:0];
            pre_b_mul = pow_rd_q[PAIR_W-1:HA_W];
          end else begin
            pre_a_mul = HA_W'(1);
            pre_b_mul = HB_W'(1);
          end
          // second prefix read while the lanes run
          pre_re   = 1'b1;
          pre_addr = AW'(32'(cmd_q.hi) - 32'd1);
          state_d  = sdrh_pkg::S_PREHI;
        end
      end
      sdrh_pkg::S_PREHI: begin
        if (cmd_q.hi != '0) begin
          pre_hi_a_d = pre_rd_q[HA_W-1:0];
          pre_hi_b_d = pre_rd_q[PAIR_W-1:HA_W];
        end else begin
          pre_hi_a_d = '0;
          pre_hi_b_d = '0;
        end
        state_d = sdrh_pkg::S_MUL;
      end
      sdrh_pkg::S_MUL: begin
        if (done_pre_a && done_pre_b && done_pow_a && done_pow_b) begin
          state_d = sdrh_pkg::S_FIX;
        end
      end
      sdrh_pkg::S_FIX: begin
        out_stat_d = sdrh_pkg::ST_OK;
        if (is_append) begin
          wr_en      = 1'b1;
          len_d      = len_q + LW'(1);
          out_ha_d   = new_a;
          out_hb_d   = new_b;
          out_span_d = SPAN_W'(len_q + LW'(1));
        end else begin
          out_ha_d   = diff_a;
          out_hb_d   = diff_b;
          out_span_d = SPAN_W'(span);
        end
        state_d = sdrh_pkg::S_OUT;
      end
      sdrh_pkg::S_OUT: begin
        if (out_o.ready) begin
          state_d = sdrh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sdrh_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdrh_pkg::S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pre_hi_a_q <= pre_hi_a_d;
    pre_hi_b_q <= pre_hi_b_d;
    out_ha_q   <= out_ha_d;
    out_hb_q   <= out_hb_d;
    out_span_q <= out_span_d;
    out_stat_q <= out_stat_d;
  end

  // prefix and power tables, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pre_mem[wr_addr] <= pre_wdata;
      pow_mem[wr_addr] <= pow_wdata;
    end
    if (pre_re) begin
      pre_rd_q <= pre_mem[pre_addr];
    end
    if (pow_re) begin
      pow_rd_q <= pow_mem[pow_addr];
    end
  end

  // lanes: prefix times base or power, power times base
  sdrh_modmul #(.W(HA_W)) u_pre_a (
    .clk_i, .rst_ni, .ctrl_i(pre_ctrl), .a_i(pre_a_op), .b_i(pre_a_mul),
    .mod_i(sdrh_pkg::MOD_A), .r_o(r_pre_a), .done_o(done_pre_a)
  );
  sdrh_modmul #(.W(HB_W)) u_pre_b (
    .clk_i, .rst_ni, .ctrl_i(pre_ctrl), .a_i(pre_b_op), .b_i(pre_b_mul),
    .mod_i(sdrh_pkg::MOD_B), .r_o(r_pre_b), .done_o(done_pre_b)
  );
  sdrh_modmul #(.W(HA_W)) u_pow_a (
    .clk_i, .rst_ni, .ctrl_i(pow_ctrl), .a_i(pow_a_op), .b_i(sdrh_pkg::BASE_A),
    .mod_i(sdrh_pkg::MOD_A), .r_o(r_pow_a), .done_o(done_pow_a)
  );
  sdrh_modmul #(.W(HB_W)) u_pow_b (
    .clk_i, .rst_ni, .ctrl_i(pow_ctrl), .a_i(pow_b_op), .b_i(sdrh_pkg::BASE_B),
    .mod_i(sdrh_pkg::MOD_B), .r_o(r_pow_b), .done_o(done_pow_b)
  );

  // result channel
  assign out_o.valid       = (state_q == sdrh_pkg::S_OUT);
  assign out_o.hash_a      = out_ha_q;
  assign out_o.hash_b      = out_hb_q;
  assign out_o.span_length = out_span_q;
  assign out_o.status      = out_stat_q;

endmodule

@@ sim/testbench.sv @@
// testbench: self-checking bench for substring_double_rolling_hash, predicting every result
// depends on sdrh_pkg, sdrh_if and the block's top level; drives and checks through the item channels
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TEXT_CAP = 4096;
  localparam int unsigned RAND_ITEMS = 600;
  localparam longint unsigned HA_BASE = 3491;
  localparam longint unsigned HA_PRIME = 481840747;
  localparam longint unsigned HB_BASE = 8761;
  localparam longint unsigned HB_PRIME = 999750347;

  typedef struct {
    sdrh_pkg::op_e                   op;
    logic [sdrh_pkg::CHAR_W-1:0]     ch;
    logic [sdrh_pkg::POS_W-1:0]      lo;
    logic [sdrh_pkg::POS_W-1:0]      hi;
    bit                              drain;
  } hash_req_t;

  typedef struct {
    logic [sdrh_pkg::HA_W-1:0]       ha;
    logic [sdrh_pkg::HB_W-1:0]       hb;
    logic [sdrh_pkg::SPAN_W-1:0]     span;
    sdrh_pkg::status_e               st;
  } hash_res_t;

  logic clk_i;
  logic rst_ni;

  sdrh_in_if  req_if ();
  sdrh_out_if res_if ();

  substring_double_rolling_hash #(
    .MAX_LEN(TEXT_CAP)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  // requests still to be sent and hashes still to arrive
  hash_req_t pending_cmds[$];
  hash_res_t expected_hashes[$];
  hash_req_t cur_req;

  // predicted text: entry k holds the hash of the first k bytes, and base^k
  logic [sdrh_pkg::HA_W-1:0] pfx_a[0:TEXT_CAP];
  logic [sdrh_pkg::HB_W-1:0] pfx_b[0:TEXT_CAP];
  logic [sdrh_pkg::HA_W-1:0] pw_a[0:TEXT_CAP];
  logic [sdrh_pkg::HB_W-1:0] pw_b[0:TEXT_CAP];
  int unsigned     txt_len = 0;

  // text length as seen while building the stimulus
  int unsigned gen_len = 0;

  int unsigned mismatches = 0;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  bit          tx_idling = 1'b1;
  bit          rx_idling = 1'b1;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hash predictor: updates the text and returns the result of one request
  function automatic hash_res_t predict_hash(input hash_req_t r);
    int unsigned     n;
    int unsigned     span;
    longint unsigned shifted_a;
    longint unsigned shifted_b;
    hash_res_t       res;
    res.ha = '0;
    res.hb = '0;
    res.span = '0;
    res.st = sdrh_pkg::ST_OK;
    case (r.op)
      sdrh_pkg::OP_APPEND: begin
        n = txt_len;
        if (n >= TEXT_CAP) begin
          res.span = sdrh_pkg::SPAN_W'(n);
          res.st = sdrh_pkg::ST_FULL;
        end else begin
          pfx_a[n+1] = sdrh_pkg::HA_W'((64'(pfx_a[n]) * HA_BASE + 64'(r.ch)) % HA_PRIME);
          pfx_b[n+1] = sdrh_pkg::HB_W'((64'(pfx_b[n]) * HB_BASE + 64'(r.ch)) % HB_PRIME);
          pw_a[n+1] = sdrh_pkg::HA_W'((64'(pw_a[n]) * HA_BASE) % HA_PRIME);
          pw_b[n+1] = sdrh_pkg::HB_W'((64'(pw_b[n]) * HB_BASE) % HB_PRIME);
          txt_len = n + 1;
          res.ha = pfx_a[n+1];
          res.hb = pfx_b[n+1];
          res.span = sdrh_pkg::SPAN_W'(txt_len);
        end
      end
      sdrh_pkg::OP_QUERY: begin
        if (r.lo < txt_len && r.lo <= r.hi && r.hi <= txt_len) begin
          span = r.hi - r.lo;
          shifted_a = (64'(pfx_a[r.lo]) * 64'(pw_a[span])) % HA_PRIME;
          shifted_b = (64'(pfx_b[r.lo]) * 64'(pw_b[span])) % HB_PRIME;
          res.ha = sdrh_pkg::HA_W'((64'(pfx_a[r.hi]) + HA_PRIME - shifted_a) % HA_PRIME);
          res.hb = sdrh_pkg::HB_W'((64'(pfx_b[r.hi]) + HB_PRIME - shifted_b) % HB_PRIME);
          res.span = sdrh_pkg::SPAN_W'(span);
        end else begin
          res.st = sdrh_pkg::ST_RANGE;
        end
      end
      sdrh_pkg::OP_CLEAR: begin
        txt_len = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report(input string what, input longint unsigned want,
                        input longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // stimulus builders, tracking the text length they lead to
  task automatic queue_req(input sdrh_pkg::op_e op, input int unsigned ch,
                           input int unsigned lo, input int unsigned hi, input bit drain);
    hash_req_t r;
    r.op = op;
    r.ch = sdrh_pkg::CHAR_W'(ch);
    r.lo = sdrh_pkg::POS_W'(lo);
    r.hi = sdrh_pkg::POS_W'(hi);
    r.drain = drain;
    pending_cmds.push_back(r);
    if (op == sdrh_pkg::OP_APPEND && gen_len < TEXT_CAP) begin
      gen_len++;
    end else if (op == sdrh_pkg::OP_CLEAR) begin
      gen_len = 0;
    end
  endtask

  task automatic queue_append(input int unsigned ch);
    queue_req(sdrh_pkg::OP_APPEND, ch, $urandom_range(0, 8191), $urandom_range(0, 8191),
              1'b0);
  endtask

  task automatic queue_query(input int unsigned lo, input int unsigned hi);
    queue_req(sdrh_pkg::OP_QUERY, $urandom_range(0, 255), lo, hi, 1'b0);
  endtask

  // a position at the start, at or around the end of the text, or anywhere in the field
  function automatic int unsigned edge_pos();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return (gen_len == 0) ? 0 : gen_len - 1;
      2: return gen_len;
      3: return gen_len + 1;
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // request driver
  always @(posedge clk_i) begin
    logic send_next;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= sdrh_pkg::OP_NONE;
      req_if.char_code <= '0;
      req_if.start_req <= '0;
      req_if.stop <= '0;
    end else begin
      send_next = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        expected_hashes.push_back(predict_hash(cur_req));
        n_sent++;
        if (n_sent % 100 == 0) begin
          tx_idling = ($urandom_range(0, 3) != 0);
        end
        tx_gap = tx_idling ? $urandom_range(0, 10) : 0;
        send_next = 1'b0;
      end
      if (!send_next) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_hashes.size() != 0)) begin
          cur_req = pending_cmds.pop_front();
          req_if.operation <= cur_req.op;
          req_if.char_code <= cur_req.ch;
          req_if.start_req <= cur_req.lo;
          req_if.stop <= cur_req.hi;
          send_next = 1'b1;
        end
      end
      req_if.valid <= send_next;
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    hash_res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_hashes.size() == 0) begin
          report("result with no request outstanding", 0, 1);
        end else begin
          want = expected_hashes.pop_front();
          if (res_if.hash_a !== want.ha) report("hash_a", want.ha, res_if.hash_a);
          if (res_if.hash_b !== want.hb) report("hash_b", want.hb, res_if.hash_b);
          if (res_if.span_length !== want.span) begin
            report("span_length", want.span, res_if.span_length);
          end
          if (res_if.status !== want.st) report("status", want.st, res_if.status);
        end
        n_recv++;
        if (n_recv % 100 == 0) begin
          rx_idling = ($urandom_range(0, 3) != 0);
        end
        rx_stall = rx_idling ? $urandom_range(0, 10) : 0;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned pick;
    int unsigned lo;
    rst_ni = 1'b0;
    pfx_a[0] = '0;
    pfx_b[0] = '0;
    pw_a[0] = sdrh_pkg::HA_W'(1);
    pw_b[0] = sdrh_pkg::HB_W'(1);

    // directed: empty text, byte extremes, range edges, unused code
    queue_query(0, 0);
    queue_req(sdrh_pkg::OP_NONE, 255, 8191, 8191, 1'b0);
    queue_req(sdrh_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    queue_append(8'hFF);
    queue_append(8'h00);
    queue_append(8'h80);
    queue_append(8'h7F);
    queue_append(8'h01);
    queue_query(0, 5);
    queue_query(2, 2);
    queue_query(4, 5);
    queue_query(0, 1);
    queue_query(5, 5);
    queue_query(0, 6);
    queue_query(3, 2);
    queue_query(8191, 8191);
    queue_query(4096, 4096);
    queue_query(1, 8191);
    queue_req(sdrh_pkg::OP_NONE, 0, 0, 0, 1'b1);
    queue_req(sdrh_pkg::OP_CLEAR, 255, 8191, 8191, 1'b0);
    queue_query(0, 0);
    queue_append(8'h55);
    queue_query(0, 1);

    // random: mostly well-formed ranges over a text that grows and is cleared
    for (int k = 0; k < RAND_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_append($urandom_range(0, 255));
      end else if (pick < 85) begin
        if (gen_len != 0 && $urandom_range(0, 4) != 0) begin
          lo = $urandom_range(0, gen_len - 1);
          queue_query(lo, $urandom_range(lo, gen_len));
        end else begin
          queue_query(edge_pos(), edge_pos());
        end
      end else if (pick < 88) begin
        queue_req(sdrh_pkg::OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 8191),
                  $urandom_range(0, 8191), 1'b0);
      end else if (pick < 90) begin
        queue_req(sdrh_pkg::OP_NONE, $urandom_range(0, 255), $urandom_range(0, 8191),
                  $urandom_range(0, 8191), 1'b0);
      end else if (pick < 92) begin
        queue_req(sdrh_pkg::OP_QUERY, $urandom_range(0, 255), edge_pos(), edge_pos(), 1'b1);
      end else begin
        // burst of bytes for longer texts
        repeat ($urandom_range(1, 40)) queue_append($urandom_range(0, 255));
      end
    end

    // full table: fill to capacity, then appends are refused
    queue_req(sdrh_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    while (gen_len < TEXT_CAP) queue_append($urandom_range(0, 255));
    queue_req(sdrh_pkg::OP_APPEND, 8'hFF, 8191, 8191, 1'b1);
    queue_append(8'h00);
    queue_query(0, TEXT_CAP);
    queue_query(TEXT_CAP - 1, TEXT_CAP);
    queue_query(TEXT_CAP - 1, TEXT_CAP - 1);
    queue_query(0, 0);
    queue_query(TEXT_CAP, TEXT_CAP);
    queue_query(TEXT_CAP, TEXT_CAP - 1);
    queue_query(0, TEXT_CAP + 1);
    repeat (20) begin
      lo = $urandom_range(0, TEXT_CAP - 1);
      queue_query(lo, $urandom_range(lo, TEXT_CAP));
    end
    queue_req(sdrh_pkg::OP_NONE, 0, 0, 0, 1'b0);
    queue_req(sdrh_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    queue_query(0, 0);
    queue_append($urandom_range(0, 255));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || req_if.valid) @(negedge clk_i);
    while (expected_hashes.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);

    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sdrh_pkg.sv
rtl/core/sdrh_if.sv
rtl/core/sdrh_front.sv
rtl/core/sdrh_fifo.sv
rtl/core/sdrh_modmul.sv
rtl/core/sdrh_back.sv
rtl/core/substring_double_rolling_hash.sv
sim/testbench.sv
